// File: hw/rtl/bloom_filter_murmur3_cubic_defines.svh
// Assertion macros used by the checker file of the Bloom filter block.
// No dependencies; include by bare file name.
`ifndef BLOOM_FILTER_MURMUR3_CUBIC_DEFINES_SVH
`define BLOOM_FILTER_MURMUR3_CUBIC_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFM3C_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BFM3C_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bfm3c_pkg.sv
// Types and fixed constants of the Bloom filter block.
// No dependencies; compile first.
package bfm3c_pkg;

   // field widths
   localparam int ID_W           = 64;
   localparam int NUM_HASHES_W   = 5;
   localparam int NUM_BITS_W     = 17;
   localparam int CSR_IDX_W      = 8;
   localparam int CSR_DATA_W     = 64;
   localparam int HASH_W         = 32;

   // probe limits
   localparam int MAX_HASHES     = 16;
   localparam int MIN_BITS       = 8;

   // MurmurHash3_32 constants
   localparam logic [HASH_W-1:0] MIX_C1  = 32'hcc9e2d51;
   localparam logic [HASH_W-1:0] MIX_C2  = 32'h1b873593;
   localparam logic [HASH_W-1:0] MIX_ADD = 32'he6546b64;
   localparam logic [HASH_W-1:0] FIN_C1  = 32'h85ebca6b;
   localparam logic [HASH_W-1:0] FIN_C2  = 32'hc2b2ae35;
   localparam logic [HASH_W-1:0] KEY_LEN = 32'd8;

   // probe arithmetic: h1 + i*h2 + i^3 stays below 2^37 for i <= 16
   localparam int XW          = 38;
   localparam int DIV_STEPS   = 2;
   localparam int DIV_CYCLES  = XW / DIV_STEPS;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
   localparam int DW          = 12;

   // actions
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_HASHES = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BITS   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ID     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ID     = 8'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_DIV,
      ST_ACCESS,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      H_IDLE,
      H_SLO_A,
      H_SLO_B,
      H_SHI_A,
      H_SHI_B,
      H_ROUND_LO,
      H_ROUND_HI,
      H_FIN_A,
      H_FIN_B,
      H_OUT
   } hash_step_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] h1;
      logic [HASH_W-1:0] h2;
   } hash_res_type;

endpackage

// File: hw/rtl/bfm3c_if.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on bfm3c_pkg.
interface bfm3c_req_if;
   import bfm3c_pkg::*;
   logic            valid;
   logic            ready;
   logic            action;
   logic [ID_W-1:0] entity_id;
   modport source (output valid, action, entity_id, input ready);
   modport sink   (input valid, action, entity_id, output ready);
endinterface

interface bfm3c_rsp_if;
   logic valid;
   logic ready;
   logic may_exist;
   modport source (output valid, may_exist, input ready);
   modport sink   (input valid, may_exist, output ready);
endinterface

interface bfm3c_csr_if;
   import bfm3c_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bfm3c_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfm3c_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hw/rtl/bfm3c_hash.sv
// Two MurmurHash3_32 values (seeds 0 and 1) of a 64-bit id on one shared multiplier.
// Depends on bfm3c_pkg.
module bfm3c_hash (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bfm3c_pkg::ID_W-1:0] entity_id,
   output bfm3c_pkg::hash_res_type   res
);
   import bfm3c_pkg::*;

   function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] x, input int r);
      return (x << r) | (x >> (HASH_W - r));
   endfunction

   // rotate 13, times 5, plus the mixing constant
   function automatic logic [HASH_W-1:0] round_mix(input logic [HASH_W-1:0] x);
      logic [HASH_W-1:0] t;
      t = rotl(x, 13);
      return t + (t << 2) + MIX_ADD;
   endfunction

   hash_step_type     step_ff, step_in;
   logic              seed_ff, seed_in;
   logic              done_ff, done_in;
   logic [HASH_W-1:0] prod_ff, prod_in;
   logic [HASH_W-1:0] slo_ff, slo_in;
   logic [HASH_W-1:0] shi_ff, shi_in;
   logic [HASH_W-1:0] h_ff, h_in;
   logic [HASH_W-1:0] h1_ff, h1_in;
   logic [HASH_W-1:0] h2_ff, h2_in;
   logic [HASH_W-1:0] mul_a, mul_b;
   logic [2*HASH_W-1:0] mul_full;
   logic [HASH_W-1:0] fin_pre, shi_cur, outv;

   // sequencer
   always_comb begin
      step_in = step_ff;
      case (step_ff)
         H_IDLE:     if (start) step_in = H_SLO_A;
         H_SLO_A:    step_in = H_SLO_B;
         H_SLO_B:    step_in = H_SHI_A;
         H_SHI_A:    step_in = H_SHI_B;
         H_SHI_B:    step_in = H_ROUND_LO;
         H_ROUND_LO: step_in = H_ROUND_HI;
         H_ROUND_HI: step_in = H_FIN_A;
         H_FIN_A:    step_in = H_FIN_B;
         H_FIN_B:    step_in = H_OUT;
         H_OUT:      step_in = seed_ff ? H_IDLE : H_ROUND_LO;
         default:    step_in = H_IDLE;
      endcase
   end

   assign fin_pre  = (h_ff ^ KEY_LEN) ^ ((h_ff ^ KEY_LEN) >> 16);
   assign outv     = prod_ff ^ (prod_ff >> 16);
   // the high scramble sits in the product register on the first round only
   assign shi_cur  = seed_ff ? shi_ff : prod_ff;
   assign mul_full = mul_a * mul_b;

   // datapath
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      seed_in = seed_ff;
      done_in = 1'b0;
      slo_in  = slo_ff;
      shi_in  = shi_ff;
      h_in    = h_ff;
      h1_in   = h1_ff;
      h2_in   = h2_ff;
      prod_in = prod_ff;
      case (step_ff)
         H_IDLE: begin
            seed_in = 1'b0;
         end
         H_SLO_A: begin
            mul_a   = entity_id[HASH_W-1:0];
            mul_b   = MIX_C1;
            prod_in = mul_full[HASH_W-1:0];
         end
         H_SLO_B: begin
            mul_a   = rotl(prod_ff, 15);
            mul_b   = MIX_C2;
            prod_in = mul_full[HASH_W-1:0];
         end
         H_SHI_A: begin
            slo_in  = prod_ff;
            mul_a   = entity_id[ID_W-1:HASH_W];
            mul_b   = MIX_C1;
            prod_in = mul_full[HASH_W-1:0];
         end
         H_SHI_B: begin
            mul_a   = rotl(prod_ff, 15);
            mul_b   = MIX_C2;
            prod_in = mul_full[HASH_W-1:0];
         end
         H_ROUND_LO: begin
            shi_in = shi_cur;
            h_in   = round_mix({{(HASH_W-1){1'b0}}, seed_ff} ^ slo_ff);
         end
         H_ROUND_HI: begin
            h_in = round_mix(h_ff ^ shi_ff);
         end
         H_FIN_A: begin
            mul_a   = fin_pre;
            mul_b   = FIN_C1;
            prod_in = mul_full[HASH_W-1:0];
         end
         H_FIN_B: begin
            mul_a   = prod_ff ^ (prod_ff >> 13);
            mul_b   = FIN_C2;
            prod_in = mul_full[HASH_W-1:0];
         end
         H_OUT: begin
            if (seed_ff) begin
               h2_in   = outv;
               done_in = 1'b1;
            end else begin
               h1_in   = outv;
               seed_in = 1'b1;
            end
         end
         default: begin
            seed_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= H_IDLE;
         seed_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         seed_ff <= seed_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      slo_ff  <= slo_in;
      shi_ff  <= shi_in;
      h_ff    <= h_in;
      h1_ff   <= h1_in;
      h2_ff   <= h2_in;
   end

   assign res.done = done_ff;
   assign res.h1   = h1_ff;
   assign res.h2   = h2_ff;
endmodule

// File: hw/rtl/bloom_filter_murmur3_cubic.sv
// Bloom filter top level: sequencer, probe arithmetic, remainder unit, bit memory.
// Depends on bfm3c_pkg, bfm3c_if, bfm3c_ram and bfm3c_hash.
//
// The block keeps a MAX_BITS-bit filter and handles one item at a time. After reset it
// runs a clearing pass, one bit a cycle, with req_chan.ready low; register writes are
// taken meanwhile. An item takes two MurmurHash3_32 values (seeds 0 and 1) over the id's
// low and high words on one shared 32x32 multiplier. Each of the k probes then forms
// h1 + i*h2 + i^3 by adding forward differences and reduces it modulo m in a restoring
// remainder unit that retires two bits a cycle, followed by a memory step: set the bit
// on insert, or read it and then test it on query. A query outside [min_id, max_id] or
// any item with k zero skips the hashes and the probes. k is num_hashes clamped to 16,
// m is num_bits clamped to [8, MAX_BITS]. Queries return one transfer on rsp_chan,
// inserts none. The result sits in an output register, so the next request is taken
// while a result still waits for rsp_chan.ready. Registers are written through
// csr_chan, which is always ready; the user must write them only while idle, as the
// block itself does not enforce it.
module bloom_filter_murmur3_cubic #(
   parameter int unsigned MAX_BITS = 65536
) (
   input  logic          clock,
   input  logic          reset,
   bfm3c_req_if.sink     req_chan,
   bfm3c_rsp_if.source   rsp_chan,
   bfm3c_csr_if.sink     csr_chan
);
   import bfm3c_pkg::*;

   localparam int AW = $clog2(MAX_BITS);
   localparam int MW = $clog2(MAX_BITS + 1);
   localparam int CW = (MW > NUM_BITS_W) ? MW : NUM_BITS_W;
   localparam logic [AW-1:0]        CLR_LAST = AW'(MAX_BITS - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

   // configuration
   logic [NUM_HASHES_W-1:0] num_hashes_ff, num_hashes_in;
   logic [NUM_BITS_W-1:0]   num_bits_ff, num_bits_in;
   logic [ID_W-1:0]         min_id_ff, min_id_in;
   logic [ID_W-1:0]         max_id_ff, max_id_in;

   // control
   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [NUM_HASHES_W-1:0] i_ff, i_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic                    query_ff, query_in;
   logic                    all_set_ff, all_set_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [HASH_W-1:0]       h2_ff, h2_in;
   logic [XW-1:0]           x_ff, x_in;
   logic [XW-1:0]           sh_ff, sh_in;
   logic [DW-1:0]           d_ff, d_in;
   logic [MW-1:0]           r_ff, r_in;
   logic                    rsp_may_ff, rsp_may_in;

   // combinational
   logic                    accept;
   logic                    in_range;
   logic                    skip_hash;
   logic                    last_probe;
   logic                    slot_free;
   logic                    hash_start;
   hash_res_type            hash_res;
   logic [NUM_HASHES_W-1:0] k_eff;
   logic [CW-1:0]           nb_ext;
   logic [MW-1:0]           m_eff;
   logic [MW-1:0]           rem_next;
   logic [XW-1:0]           x_next;
   logic [DW-1:0]           d_step;
   logic [AW-1:0]           pos;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic                    ram_wdata;
   logic                    ram_rdata;

   // ---------------------------------------------------------------------------------
   // Register file: csr_chan is always ready; unknown indexes drop silently.
   // ---------------------------------------------------------------------------------
   assign csr_chan.ready = 1'b1;

   always_comb begin
      num_hashes_in = num_hashes_ff;
      num_bits_in   = num_bits_ff;
      min_id_in     = min_id_ff;
      max_id_in     = max_id_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_NUM_HASHES: num_hashes_in = csr_chan.data[NUM_HASHES_W-1:0];
            CSR_NUM_BITS:   num_bits_in   = csr_chan.data[NUM_BITS_W-1:0];
            CSR_MIN_ID:     min_id_in     = csr_chan.data[ID_W-1:0];
            CSR_MAX_ID:     max_id_in     = csr_chan.data[ID_W-1:0];
            default:        num_hashes_in = num_hashes_ff;
         endcase
      end
   end

   // Effective probe count and bit count.
   assign k_eff  = (num_hashes_ff > NUM_HASHES_W'(MAX_HASHES)) ?
                   NUM_HASHES_W'(MAX_HASHES) : num_hashes_ff;
   assign nb_ext = CW'(num_bits_ff);
   assign m_eff  = (nb_ext < CW'(MIN_BITS)) ? MW'(MIN_BITS) :
                   (nb_ext > CW'(MAX_BITS)) ? MW'(MAX_BITS) : MW'(nb_ext);

   // ---------------------------------------------------------------------------------
   // Handshake helpers
   // ---------------------------------------------------------------------------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_range       = (req_chan.entity_id >= min_id_ff) &&
                           (req_chan.entity_id <= max_id_ff);
   // out-of-range queries and zero probes never need the hashes
   assign skip_hash      = ((req_chan.action == ACT_QUERY) && !in_range) ||
                           (k_eff == '0);
   assign hash_start     = accept && !skip_hash;
   assign last_probe     = ((i_ff + NUM_HASHES_W'(1)) == k_eff);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   bfm3c_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (hash_start),
      .entity_id (id_ff),
      .res       (hash_res)
   );

   // ---------------------------------------------------------------------------------
   // Remainder unit: shift the probe value in MSB first, DIV_STEPS bits a cycle,
   // subtract m whenever the partial remainder reaches it.
   // ---------------------------------------------------------------------------------
   always_comb begin
      logic [MW:0]   t;
      logic [MW-1:0] rem;
      rem = r_ff;
      for (int s = 0; s < DIV_STEPS; s++) begin
         t = {rem, sh_ff[XW-1-s]};
         if (t >= {1'b0, m_eff}) begin
            t = t - {1'b0, m_eff};
         end
         rem = t[MW-1:0];
      end
      rem_next = rem;
   end

   assign pos = r_ff[AW-1:0];

   // Forward differences: x(i+1) = x(i) + h2 + d(i), d(i) = 3i^2 + 3i + 1,
   // d(i+1) = d(i) + 6(i+1).
   assign d_step = DW'(i_ff + NUM_HASHES_W'(1)) * DW'(6);
   assign x_next = x_ff + XW'(h2_ff) + XW'(d_ff);

   // ---------------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = skip_hash ? ST_DONE : ST_HASH;
         ST_HASH:   if (hash_res.done) state_in = ST_DIV;
         ST_DIV:    if (div_cnt_ff == DIV_LAST) state_in = ST_ACCESS;
         ST_ACCESS: state_in = query_ff ? ST_CHECK : (last_probe ? ST_DONE : ST_DIV);
         ST_CHECK:  state_in = (i_ff == k_eff) ? ST_DONE : ST_DIV;
         ST_DONE:   if (!query_ff || slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Datapath and outputs
   // ---------------------------------------------------------------------------------
   always_comb begin
      clr_in       = clr_ff;
      div_cnt_in   = div_cnt_ff;
      i_in         = i_ff;
      query_in     = query_ff;
      all_set_in   = all_set_ff;
      id_in        = id_ff;
      h2_in        = h2_ff;
      x_in         = x_ff;
      sh_in        = sh_ff;
      d_in         = d_ff;
      r_in         = r_ff;
      rsp_may_in   = rsp_may_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ram_we       = 1'b0;
      ram_waddr    = pos;
      ram_wdata    = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 1'b0;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               query_in   = req_chan.action;
               id_in      = req_chan.entity_id;
               all_set_in = !((req_chan.action == ACT_QUERY) && !in_range);
            end
         end
         ST_HASH: begin
            // first probe: h1 alone
            if (hash_res.done) begin
               x_in       = XW'(hash_res.h1);
               sh_in      = XW'(hash_res.h1);
               h2_in      = hash_res.h2;
               d_in       = DW'(1);
               i_in       = '0;
               r_in       = '0;
               div_cnt_in = '0;
            end
         end
         ST_DIV: begin
            r_in       = rem_next;
            sh_in      = sh_ff << DIV_STEPS;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         ST_ACCESS: begin
            // set on insert; on query the read returns next cycle
            ram_we     = !query_ff;
            i_in       = i_ff + NUM_HASHES_W'(1);
            x_in       = x_next;
            sh_in      = x_next;
            d_in       = d_ff + d_step;
            r_in       = '0;
            div_cnt_in = '0;
         end
         ST_CHECK: begin
            if (!ram_rdata) begin
               all_set_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (query_ff && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_may_in   = all_set_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   bfm3c_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_bits (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (pos),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         div_cnt_ff    <= '0;
         i_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
         num_hashes_ff <= NUM_HASHES_W'(4);
         num_bits_ff   <= NUM_BITS_W'(65536);
         min_id_ff     <= '0;
         max_id_ff     <= '1;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         div_cnt_ff    <= div_cnt_in;
         i_ff          <= i_in;
         rsp_valid_ff  <= rsp_valid_in;
         num_hashes_ff <= num_hashes_in;
         num_bits_ff   <= num_bits_in;
         min_id_ff     <= min_id_in;
         max_id_ff     <= max_id_in;
      end
      query_ff   <= query_in;
      all_set_ff <= all_set_in;
      id_ff      <= id_in;
      h2_ff      <= h2_in;
      x_ff       <= x_in;
      sh_ff      <= sh_in;
      d_ff       <= d_in;
      r_ff       <= r_in;
      rsp_may_ff <= rsp_may_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.may_exist = rsp_may_ff;
endmodule

// File: hw/rtl/bfm3c_checker.sv
// Port-level checks of the Bloom filter top level, bound to it below.
// Depends on bloom_filter_murmur3_cubic_defines.svh.
`include "bloom_filter_murmur3_cubic_defines.svh"

module bfm3c_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_may_exist
);
   // one item at a time: the request side closes right after a transfer
   `BFM3C_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   // a new result appears only at the end of an item's work
   `BFM3C_ASSERT_IMP(a_rsp_from_busy, clock, reset, $rose(rsp_valid), !$past(req_ready), "result appeared while idle")
   // a stalled result stays offered
   `BFM3C_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped before transfer")
   // and its value does not change
   `BFM3C_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_may_exist), "stalled result changed")
endmodule

bind bloom_filter_murmur3_cubic bfm3c_checker u_bfm3c_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_may_exist (rsp_chan.may_exist)
);

// File: dv/tb_bloom_filter_murmur3_cubic.sv
// Self-checking testbench for bloom_filter_murmur3_cubic: directed and random traffic.
// Keeps a bit-exact shadow filter and scores every query response against it.
// Depends on bfm3c_pkg, bfm3c_if and the RTL of the block.
module tb_bloom_filter_murmur3_cubic;
   timeunit 1ns;
   timeprecision 1ps;
   import bfm3c_pkg::*;

   localparam int FILTER_BITS     = 65536;
   // drain time for the longest item, a query with 16 probes, rounded up
   localparam int DRAIN_CYCLES    = 400;
   // long receiver hold-off, enough for a burst of cheap queries to back up
   localparam int HOLD_CYCLES     = 2000;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 105;
   // covers the clearing pass, then about 1300 items with sender gaps and receiver
   // stalls, plus drains and the hold-off; several times over that
   localparam int LIMIT_CYCLES    = 3_000_000;

   logic clock = 1'b0;
   logic reset;

   bfm3c_req_if req_chan ();
   bfm3c_rsp_if rsp_chan ();
   bfm3c_csr_if csr_chan ();

   bloom_filter_murmur3_cubic #(
      .MAX_BITS(FILTER_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // shadow copy of the filter state and its registers
   bit                    shadow_bits [FILTER_BITS];
   logic [4:0]            cfg_probes;
   logic [16:0]           cfg_bits;
   logic [63:0]           cfg_lo;
   logic [63:0]           cfg_hi;
   bit                    may_exist_expected [$];
   bit                    expected_bit;
   int                    fail_count = 0;
   longint                cycle_count = 0;

   // stimulus knobs
   bit                    req_idling;
   bit                    rsp_idling;
   int                    hold_req = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    stall_left = 0;
   logic [63:0]           id_pool [$];
   logic [63:0]           cur_lo;
   logic [63:0]           cur_hi;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow filter: MurmurHash3_32 over the id's two words, cubic probing
   // ---------------------------------------------------------------------------
   function automatic logic [31:0] scramble_word(input logic [31:0] w);
      w = w * MIX_C1;
      w = {w[16:0], w[31:17]};
      return w * MIX_C2;
   endfunction

   function automatic logic [31:0] murmur_entity(input logic [63:0] id,
                                                 input logic [31:0] seed);
      logic [31:0] h;
      h = seed ^ scramble_word(id[31:0]);
      h = {h[18:0], h[31:19]};
      h = h * 32'd5 + MIX_ADD;
      h = h ^ scramble_word(id[63:32]);
      h = {h[18:0], h[31:19]};
      h = h * 32'd5 + MIX_ADD;
      // finalize with the key length of eight bytes
      h = h ^ KEY_LEN;
      h = h ^ (h >> 16);
      h = h * FIN_C1;
      h = h ^ (h >> 13);
      h = h * FIN_C2;
      return h ^ (h >> 16);
   endfunction

   // Apply one request to the shadow filter; return may_exist for a query.
   function automatic bit probe_filter(input logic act, input logic [63:0] id);
      logic [63:0] h1, h2, i, span, pos;
      int unsigned probes;
      bit          all_set;
      all_set = 1'b1;
      // out-of-range queries never touch the array; inserts ignore the range
      if (act == ACT_QUERY && (id < cfg_lo || id > cfg_hi))
         return 1'b0;
      probes = (cfg_probes > MAX_HASHES) ? MAX_HASHES : cfg_probes;
      span   = (cfg_bits < MIN_BITS) ? MIN_BITS :
               (cfg_bits > FILTER_BITS) ? FILTER_BITS : cfg_bits;
      h1     = {32'b0, murmur_entity(id, 32'd0)};
      h2     = {32'b0, murmur_entity(id, 32'd1)};
      for (i = 0; i < probes; i++) begin
         pos = (h1 + i * h2 + i * i * i) % span;
         if (act == ACT_QUERY) begin
            if (!shadow_bits[pos]) all_set = 1'b0;
         end else begin
            shadow_bits[pos] = 1'b1;
         end
      end
      return all_set;
   endfunction

   // ---------------------------------------------------------------------------
   // Scoreboard: score responses first, then predict from the request transfer
   // and track register writes, all sampled at the same rising edge.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         foreach (shadow_bits[j]) shadow_bits[j] = 1'b0;
         cfg_probes = 5'd4;
         cfg_bits   = 17'd65536;
         cfg_lo     = '0;
         cfg_hi     = '1;
         may_exist_expected.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (may_exist_expected.size() == 0) begin
               $error("may_exist: expected none, actual %0b", rsp_chan.may_exist);
               fail_count++;
            end else begin
               expected_bit = may_exist_expected.pop_front();
               if (rsp_chan.may_exist !== expected_bit) begin
                  $error("may_exist: expected %0b, actual %0b",
                         expected_bit, rsp_chan.may_exist);
                  fail_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_bit = probe_filter(req_chan.action, req_chan.entity_id);
            if (req_chan.action == ACT_QUERY)
               may_exist_expected.push_back(expected_bit);
         end
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_NUM_HASHES: cfg_probes = csr_chan.data[4:0];
               CSR_NUM_BITS:   cfg_bits   = csr_chan.data[16:0];
               CSR_MIN_ID:     cfg_lo     = csr_chan.data;
               CSR_MAX_ID:     cfg_hi     = csr_chan.data;
               default: ;
            endcase
         end
      end
   end

   // Response ready: random stall bursts, plus a long hold-off on request.
   initial begin
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Offer one request and return at the edge of its transfer; valid stays high
   // so a back-to-back item can follow with valid never going low in between.
   task automatic send_item(input logic act, input logic [63:0] id);
      int gap;
      if (req_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.action    <= act;
      req_chan.entity_id <= id;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop the request and hold until every outstanding query has answered.
   task automatic pause_sender();
      req_chan.valid <= 1'b0;
      while (may_exist_expected.size() != 0) @(posedge clock);
   endtask

   // Also let a trailing insert finish, since it produces nothing to wait on.
   task automatic settle();
      pause_sender();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // Write all four registers; call only while the block is idle.
   task automatic program_filter(input logic [63:0] k_raw, input logic [63:0] m_raw,
                                 input logic [63:0] lo, input logic [63:0] hi);
      write_csr(CSR_NUM_HASHES, k_raw);
      write_csr(CSR_NUM_BITS, m_raw);
      write_csr(CSR_MIN_ID, lo);
      write_csr(CSR_MAX_ID, hi);
      csr_chan.valid <= 1'b0;
      cur_lo = lo;
      cur_hi = hi;
   endtask

   function automatic logic [63:0] random_entity();
      case ($urandom_range(0, 7))
         0:       return 64'($urandom_range(0, 255));
         1:       return {32'hffff_ffff, 32'($urandom)};
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   // Ids on either side of each range limit.
   function automatic logic [63:0] boundary_id();
      case ($urandom_range(0, 3))
         0:       return cur_lo - 64'd1;
         1:       return cur_lo;
         2:       return cur_hi;
         default: return cur_hi + 64'd1;
      endcase
   endfunction

   // Pick a random setting; unused upper bits of the narrow registers carry noise.
   task automatic random_setup();
      logic [63:0] k_raw, m_raw, lo, hi, base;
      int          r;
      k_raw = {32'($urandom), 32'($urandom)};
      m_raw = {32'($urandom), 32'($urandom)};
      r = $urandom_range(0, 19);
      // keep most probe counts low to bound the run length
      if (r < 12)      k_raw[4:0] = 5'($urandom_range(0, 8));
      else if (r < 16) k_raw[4:0] = 5'($urandom_range(9, 16));
      else             k_raw[4:0] = 5'($urandom_range(17, 31));
      case ($urandom_range(0, 9))
         0:       m_raw[16:0] = 17'($urandom_range(0, 7));
         1:       m_raw[16:0] = 17'($urandom_range(8, 64));
         2, 3:    m_raw[16:0] = 17'($urandom_range(65, 65535));
         4, 5:    m_raw[16:0] = 17'd65536;
         6:       m_raw[16:0] = 17'($urandom_range(65537, 131071));
         default: m_raw[16:0] = 17'($urandom_range(1, 8191) * 8);
      endcase
      lo = '0;
      hi = '1;
      case ($urandom_range(0, 5))
         2: begin
            lo = random_entity();
            hi = random_entity();
         end
         3: begin
            if (id_pool.size() != 0) begin
               base = id_pool[$urandom_range(0, id_pool.size() - 1)];
               lo   = base - 64'($urandom_range(0, 1000));
               hi   = base + 64'($urandom_range(0, 1000));
            end
         end
         4: begin
            // empty range
            lo = random_entity() | 64'h1000;
            hi = lo - 64'($urandom_range(1, 100));
         end
         5: begin
            if ($urandom_range(0, 1)) hi = random_entity();
            else                      lo = random_entity();
         end
         default: ;
      endcase
      program_filter(k_raw, m_raw, lo, hi);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset settings: four probes, full array, full id range.
   task automatic test_reset_defaults();
      send_item(ACT_QUERY, 64'd0);
      send_item(ACT_INSERT, 64'd0);
      send_item(ACT_QUERY, 64'd0);
      send_item(ACT_INSERT, '1);
      send_item(ACT_QUERY, '1);
      send_item(ACT_QUERY, 64'h8000_0000_0000_0000);
   endtask

   // Zero probes, a count above the limit, and noise in the register's upper bits.
   task automatic test_probe_count_edges();
      settle();
      program_filter(64'd0, 64'd65536, '0, '1);
      send_item(ACT_INSERT, 64'h0123_4567_89ab_cdef);
      send_item(ACT_QUERY, 64'hfedc_ba98_7654_3210);
      settle();
      program_filter(64'd31, 64'd65536, '0, '1);
      send_item(ACT_INSERT, 64'h5555_aaaa_5555_aaaa);
      send_item(ACT_QUERY, 64'h5555_aaaa_5555_aaaa);
      settle();
      program_filter(64'hffff_ffff_ffff_fff0, 64'd65536, '0, '1);
      send_item(ACT_QUERY, 64'h5555_aaaa_5555_aaaa);
   endtask

   // Bit counts below the floor, not a multiple of eight, and above the array size.
   task automatic test_bit_count_edges();
      settle();
      program_filter(64'd3, 64'd0, '0, '1);
      send_item(ACT_INSERT, 64'h0000_0001_0000_0002);
      send_item(ACT_QUERY, 64'h0000_0001_0000_0002);
      settle();
      program_filter(64'd3, 64'd13, '0, '1);
      send_item(ACT_INSERT, 64'h00ff_00ff_00ff_00ff);
      send_item(ACT_QUERY, 64'h1234_0000_0000_4321);
      settle();
      program_filter(64'd5, 64'hffff_ffff_ffff_ffff, '0, '1);
      send_item(ACT_QUERY, 64'h00ff_00ff_00ff_00ff);
      settle();
      program_filter(64'd2, 64'hffff_ffff_fffe_0010, '0, '1);
      send_item(ACT_QUERY, 64'h0000_0001_0000_0002);
   endtask

   // Range limits on both sides, inserts outside the range, then an empty range.
   task automatic test_id_range();
      settle();
      program_filter(64'd2, 64'd4096, 64'd100, 64'd200);
      send_item(ACT_INSERT, 64'd50);
      send_item(ACT_INSERT, 64'd99);
      send_item(ACT_INSERT, 64'd100);
      send_item(ACT_QUERY, 64'd99);
      send_item(ACT_QUERY, 64'd100);
      send_item(ACT_QUERY, 64'd200);
      send_item(ACT_QUERY, 64'd201);
      send_item(ACT_QUERY, 64'd50);
      settle();
      program_filter(64'd2, 64'd4096, 64'd500, 64'd400);
      send_item(ACT_QUERY, 64'd450);
      send_item(ACT_QUERY, 64'd100);
   endtask

   // Hold the response side off while queries keep coming, so the output
   // register fills and the request side stalls; then wait for every answer.
   task automatic test_output_backpressure();
      logic [63:0] id;
      int          n;
      settle();
      program_filter(64'd2, 64'd4096, '0, '1);
      req_idling = 1'b0;
      for (n = 0; n < 4; n++) begin
         id = random_entity();
         id_pool.push_back(id);
         send_item(ACT_INSERT, id);
      end
      hold_req <= hold_req + 1;
      for (n = 0; n < 20; n++) begin
         if (n % 2 == 0) send_item(ACT_QUERY, id_pool[$urandom_range(0, id_pool.size() - 1)]);
         else            send_item(ACT_QUERY, random_entity());
      end
      pause_sender();
      req_idling = 1'b1;
   endtask

   // Phases of random settings; inserts feed a pool that later queries draw on.
   // The last phase runs with no idling on either side.
   task automatic test_random_traffic();
      logic [63:0] id;
      int          phase, n, r;
      bit          last;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         random_setup();
         last = (phase == RANDOM_PHASES - 1);
         req_idling = !last && ($urandom_range(0, 3) != 0);
         rsp_idling <= !last && ($urandom_range(0, 3) != 0);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // sometimes stop mid-phase until every answer is back
            if (n == ITEMS_PER_PHASE / 2 && $urandom_range(0, 2) == 0)
               pause_sender();
            r = $urandom_range(0, 99);
            if (r < 40 || id_pool.size() == 0) begin
               id = random_entity();
               id_pool.push_back(id);
               send_item(ACT_INSERT, id);
            end else if (r < 70) begin
               send_item(ACT_QUERY, id_pool[$urandom_range(0, id_pool.size() - 1)]);
            end else if (r < 80) begin
               send_item(ACT_QUERY, boundary_id());
            end else if (r < 88) begin
               if ($urandom_range(0, 1))
                  send_item(ACT_INSERT, id_pool[$urandom_range(0, id_pool.size() - 1)]);
               else
                  send_item(ACT_INSERT, boundary_id());
            end else begin
               send_item(ACT_QUERY, random_entity());
            end
            if (id_pool.size() > 256) void'(id_pool.pop_front());
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.action    <= ACT_INSERT;
      req_chan.entity_id <= '0;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= CSR_NUM_HASHES;
      csr_chan.data      <= '0;
      req_idling          = 1'b1;
      rsp_idling         <= 1'b1;
      cur_lo              = '0;
      cur_hi              = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // the block clears its array first; the first request waits on ready
      test_reset_defaults();
      test_probe_count_edges();
      test_bit_count_edges();
      test_id_range();
      test_output_backpressure();
      test_random_traffic();
      settle();

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
